// ===== src/periodic_task_release_tracker_unit_macros.svh =====
// Assertion macros shared by the tracker RTL.
`ifndef PERIODIC_TASK_RELEASE_TRACKER_UNIT_MACROS_SVH
`define PERIODIC_TASK_RELEASE_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PTRT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PTRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ptrt_pkg.sv =====
// Types and constants of the periodic task release tracker.
package ptrt_pkg;

   localparam int CSR_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD_TICKS      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXECUTION_TICKS   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELATIVE_DEADLINE = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JITTER_LIMIT      = 2'd3;

   localparam logic [CSR_WIDTH-1:0] PERIOD_TICKS_RESET      = 16'd100;
   localparam logic [CSR_WIDTH-1:0] EXECUTION_TICKS_RESET   = 16'd10;
   localparam logic [CSR_WIDTH-1:0] RELATIVE_DEADLINE_RESET = 16'd100;
   localparam logic [CSR_WIDTH-1:0] JITTER_LIMIT_RESET      = 16'd10;

   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_EXECUTE = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [1:0] ERR_NONE          = 2'd0;
   localparam logic [1:0] ERR_DEADLINE_MISS = 2'd1;
   localparam logic [1:0] ERR_EXEC_COMPLETE = 2'd2;
   localparam logic [1:0] ERR_IGNORED       = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] jitter_draw;
   } req_item_type;

   typedef struct packed {
      logic       arrived;
      logic       renewed;
      logic       job_done;
      logic [1:0] error_code;
      logic       ready_flag;
      logic       fresh_flag;
      logic       complete_flag;
      logic       new_period_flag;
   } rsp_item_type;

endpackage

// ===== src/periodic_task_release_tracker_unit.sv =====
// Top level of the periodic task release tracker.
// The tracker follows one periodic real-time task and answers every item
// with exactly one result item. An item is taken in the cycle it is offered
// unless the result register is full and stalled; its result appears in the
// next cycle. Counters update in the cycle the item is taken, so, stalls
// aside, the rate is one item per clock. The result register decouples the
// two channels, so a new item is accepted in the same cycle the previous
// result is taken. Configuration registers must be written only while no
// item is in flight; this is not enforced. Counters are COUNT_WIDTH bits
// wide; register values are cut or zero-extended to that width when loaded.
module periodic_task_release_tracker_unit #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  ptrt_pkg::req_item_type                  req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output ptrt_pkg::rsp_item_type                  rsp_data,
   input  logic                                    csr_write_en,
   input  logic [ptrt_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ptrt_pkg::CSR_WIDTH-1:0]          csr_wdata
);
   import ptrt_pkg::*;

   `include "periodic_task_release_tracker_unit_macros.svh"

   logic [CSR_WIDTH-1:0]   period_ticks_ff;
   logic [CSR_WIDTH-1:0]   execution_ticks_ff;
   logic [CSR_WIDTH-1:0]   relative_deadline_ff;
   logic [CSR_WIDTH-1:0]   jitter_limit_ff;

   logic [COUNT_WIDTH-1:0] work_left_ff, work_left_in;
   logic [COUNT_WIDTH-1:0] deadline_left_ff, deadline_left_in;
   logic [COUNT_WIDTH-1:0] period_left_ff, period_left_in;
   logic [COUNT_WIDTH-1:0] jitter_left_ff, jitter_left_in;
   logic                   started_ff, started_in;
   logic                   faulted_ff, faulted_in;

   logic                   rsp_valid_ff;
   rsp_item_type           rsp_data_ff, rsp_data_in;

   logic                   in_accept;
   logic [CSR_WIDTH-1:0]   draw_clamped;
   logic [COUNT_WIDTH-1:0] exec_load;
   logic [COUNT_WIDTH-1:0] deadline_load;
   logic [COUNT_WIDTH-1:0] period_load;
   logic [COUNT_WIDTH-1:0] jitter_load;
   logic                   jitter_enabled;
   logic                   active;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign in_accept = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign draw_clamped   = (req_data.jitter_draw >= jitter_limit_ff) ?
                           (jitter_limit_ff - CSR_WIDTH'(1)) : req_data.jitter_draw;
   assign exec_load      = COUNT_WIDTH'(execution_ticks_ff);
   assign deadline_load  = COUNT_WIDTH'(relative_deadline_ff);
   assign period_load    = COUNT_WIDTH'(period_ticks_ff);
   assign jitter_load    = COUNT_WIDTH'(draw_clamped);
   assign jitter_enabled = (jitter_limit_ff != '0);
   assign active         = started_ff & ~faulted_ff;

   always_comb begin
      work_left_in     = work_left_ff;
      deadline_left_in = deadline_left_ff;
      period_left_in   = period_left_ff;
      jitter_left_in   = jitter_left_ff;
      started_in       = started_ff;
      faulted_in       = faulted_ff;
      rsp_data_in      = '0;
      rsp_data_in.error_code = ERR_NONE;

      case (req_data.kind)
         KIND_RESTART: begin
            work_left_in     = exec_load;
            deadline_left_in = deadline_load;
            period_left_in   = period_load;
            if (jitter_enabled) begin
               jitter_left_in = jitter_load;
            end
            started_in = 1'b1;
            faulted_in = 1'b0;
         end
         KIND_TICK: begin
            if (!active) begin
               rsp_data_in.error_code = ERR_IGNORED;
            end else begin
               if (work_left_ff != '0) begin
                  deadline_left_in = deadline_left_ff - COUNT_WIDTH'(1);
               end
               if (deadline_left_in == '0) begin
                  rsp_data_in.error_code = ERR_DEADLINE_MISS;
                  faulted_in = 1'b1;
               end else begin
                  period_left_in = period_left_ff - COUNT_WIDTH'(1);
                  if (period_left_in == '0) begin
                     work_left_in     = exec_load;
                     deadline_left_in = deadline_load;
                     period_left_in   = period_load;
                     if (jitter_enabled) begin
                        jitter_left_in = jitter_load;
                     end
                     rsp_data_in.renewed = 1'b1;
                  end
                  rsp_data_in.arrived = rsp_data_in.renewed & (jitter_left_in == '0);
                  if (jitter_left_in != '0) begin
                     jitter_left_in = jitter_left_in - COUNT_WIDTH'(1);
                     rsp_data_in.arrived = (jitter_left_in == '0);
                  end
               end
            end
         end
         KIND_EXECUTE: begin
            if (!active) begin
               rsp_data_in.error_code = ERR_IGNORED;
            end else if (work_left_ff == '0) begin
               rsp_data_in.error_code = ERR_EXEC_COMPLETE;
               faulted_in = 1'b1;
            end else begin
               work_left_in = work_left_ff - COUNT_WIDTH'(1);
               rsp_data_in.job_done = (work_left_in == '0);
            end
         end
         default: begin
            rsp_data_in.error_code = ERR_IGNORED;
         end
      endcase

      rsp_data_in.ready_flag      = (work_left_in != '0) & (jitter_left_in == '0);
      rsp_data_in.fresh_flag      = (work_left_in == exec_load);
      rsp_data_in.complete_flag   = (work_left_in == '0);
      rsp_data_in.new_period_flag = (period_left_in == period_load);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ticks_ff      <= PERIOD_TICKS_RESET;
         execution_ticks_ff   <= EXECUTION_TICKS_RESET;
         relative_deadline_ff <= RELATIVE_DEADLINE_RESET;
         jitter_limit_ff      <= JITTER_LIMIT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PERIOD_TICKS:      period_ticks_ff      <= csr_wdata;
            CSR_EXECUTION_TICKS:   execution_ticks_ff   <= csr_wdata;
            CSR_RELATIVE_DEADLINE: relative_deadline_ff <= csr_wdata;
            CSR_JITTER_LIMIT:      jitter_limit_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_left_ff     <= '0;
         deadline_left_ff <= '0;
         period_left_ff   <= '0;
         jitter_left_ff   <= '0;
         started_ff       <= 1'b0;
         faulted_ff       <= 1'b0;
      end else if (in_accept) begin
         work_left_ff     <= work_left_in;
         deadline_left_ff <= deadline_left_in;
         period_left_ff   <= period_left_in;
         jitter_left_ff   <= jitter_left_in;
         started_ff       <= started_in;
         faulted_ff       <= faulted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // An accepted item always leaves a result behind in the next cycle.
   `PTRT_ASSERT_NEXT(a_result_follows_item, in_accept, rsp_valid_ff, "accepted item lost its result")
   // A fault can only arise on a task that has been started.
   `PTRT_ASSERT_NOW(a_fault_needs_start, faulted_ff, started_ff, "faulted task was never started")
   // Before the first restart the counters keep their reset value.
   `PTRT_ASSERT_NOW(a_idle_counters, !started_ff, (period_left_ff == '0) && (work_left_ff == '0), "counters moved before start")
   // A restart never reports an error.
   `PTRT_ASSERT_NEXT(a_restart_clean, in_accept && (req_data.kind == KIND_RESTART), rsp_data_ff.error_code == ERR_NONE, "restart reported an error")

endmodule
